>>> hdl/ftwa_pkg.sv
// ----------------------------------------------------------------------------
// ftwa_pkg
// Shared types and constants for the flow table with idle timeout.
// ----------------------------------------------------------------------------
package ftwa_pkg;
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] ST_HIT     = 3'd0;
    localparam logic [2:0] ST_INS     = 3'd1;
    localparam logic [2:0] ST_INS_PRG = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_BYPASS  = 3'd4;

    localparam logic [31:0] RESET_IDLE_TIMEOUT = 32'd5;

    typedef struct packed {
        logic        is_ipv4;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  protocol;
        logic [31:0] now;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot;
        logic [31:0] packet_count;
        logic [6:0]  occupancy;
        logic [6:0]  purged;
    } t_out_item;

    // classified item passed from front to back
    typedef struct packed {
        logic        is_ipv4;
        logic [63:0] kaddr;
        logic [39:0] kpp;
        logic [31:0] now;
    } t_key_item;
endpackage

>>> hdl/ftwa_if.sv
// ----------------------------------------------------------------------------
// ftwa_in_if / ftwa_out_if / ftwa_cfg_if
// Valid/ready channels of the flow table.
// ----------------------------------------------------------------------------
interface ftwa_in_if import ftwa_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ftwa_out_if import ftwa_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ftwa_cfg_if ();
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/ftwa_front.sv
// ----------------------------------------------------------------------------
// ftwa_front
// Accepts packets, builds the symmetric key, queues it for the table engine.
// ----------------------------------------------------------------------------
module ftwa_front import ftwa_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ftwa_in_if.sink         in_ch,
    output logic            o_q_valid,
    output t_key_item       o_q_data,
    input  logic            i_q_pop
);
    localparam int QD = 2;

    t_key_item r_q [QD];
    logic      r_wp, r_rp;
    logic [1:0] r_cnt;
    t_key_item n_key;
    logic      push;

    always_comb begin
        n_key.is_ipv4 = in_ch.data.is_ipv4;
        n_key.kaddr = (in_ch.data.src_addr > in_ch.data.dst_addr)
            ? {in_ch.data.src_addr, in_ch.data.dst_addr}
            : {in_ch.data.dst_addr, in_ch.data.src_addr};
        n_key.kpp = (in_ch.data.src_port > in_ch.data.dst_port)
            ? {in_ch.data.src_port, in_ch.data.dst_port, in_ch.data.protocol}
            : {in_ch.data.dst_port, in_ch.data.src_port, in_ch.data.protocol};
        n_key.now = in_ch.data.now;
    end

    assign in_ch.ready = (r_cnt != 2'd2);
    assign push = in_ch.valid && in_ch.ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= n_key;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end
endmodule

>>> hdl/ftwa_back.sv
// ----------------------------------------------------------------------------
// ftwa_back
// Table engine: sequential search, insert, purge walk over the entry memory.
// ----------------------------------------------------------------------------
module ftwa_back import ftwa_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  t_key_item       i_q_data,
    output logic            o_q_pop,
    ftwa_cfg_if.sink        cfg_ch,
    ftwa_out_if.source      out_ch
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRCH  = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_PURGE = 3'd3;
    localparam logic [2:0] S_PCHK  = 3'd4;
    localparam logic [2:0] S_WR    = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [103:0] r_key_mem [TABLE_DEPTH];
    logic [31:0]  r_cnt_mem [TABLE_DEPTH];
    logic [31:0]  r_ls_mem  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;

    logic [2:0]   r_state;
    t_key_item    r_item;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_rd_idx;
    logic [103:0] r_rd_key;
    logic [31:0]  r_rd_cnt, r_rd_ls;
    logic [CNT_W-1:0] r_stored, r_removed;
    logic [31:0]  r_timeout;
    logic [2:0]   r_status;
    logic [IDX_W-1:0] r_slot;
    logic [31:0]  r_count;
    logic         r_hit;
    logic         r_out_valid;
    t_out_item    r_out;

    logic [IDX_W-1:0] free_idx;
    logic             free_any;
    logic [IDX_W-1:0] ridx;

    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_idx = IDX_W'(k);
                free_any = 1'b1;
            end
        end
    end

    assign ridx = r_idx;
    assign cfg_ch.ready = 1'b1;
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid && !r_out_valid;
    assign out_ch.valid = r_out_valid;
    assign out_ch.data = r_out;

    always_ff @(posedge i_clk) begin
        if (r_state == S_SRCH || r_state == S_PURGE) begin
            r_rd_key <= r_key_mem[ridx];
            r_rd_cnt <= r_cnt_mem[ridx];
            r_rd_ls  <= r_ls_mem[ridx];
            r_rd_idx <= ridx;
        end
        if (r_state == S_WR) begin
            if (r_hit) begin
                r_cnt_mem[r_slot] <= r_count;
                r_ls_mem[r_slot] <= r_item.now;
            end else if (free_any) begin
                r_key_mem[free_idx] <= {r_item.kaddr, r_item.kpp};
                r_cnt_mem[free_idx] <= '0;
                r_ls_mem[free_idx] <= r_item.now;
            end
        end
        if (o_q_pop) r_item <= i_q_data;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_stored <= '0;
            r_timeout <= RESET_IDLE_TIMEOUT;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_ch.valid) r_timeout <= cfg_ch.data;
            if (out_ch.valid && out_ch.ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_idx <= '0;
                        r_removed <= '0;
                        r_hit <= 1'b0;
                        r_count <= '0;
                        r_slot <= '0;
                        if (!i_q_data.is_ipv4) begin
                            r_status <= ST_BYPASS;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SRCH;
                        end
                    end
                end
                S_SRCH: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_valid[r_rd_idx] && r_rd_key == {r_item.kaddr, r_item.kpp}) begin
                        r_hit <= 1'b1;
                        r_slot <= r_rd_idx;
                        r_status <= ST_HIT;
                        r_count <= (r_rd_cnt == 32'hFFFF_FFFF) ? r_rd_cnt : r_rd_cnt + 32'd1;
                        r_state <= S_WR;
                    end else if (r_idx == IDX_W'(TABLE_DEPTH - 1)) begin
                        r_idx <= '0;
                        if (r_stored == CNT_W'(TABLE_DEPTH)) begin
                            r_state <= S_PURGE;
                        end else begin
                            r_slot <= free_idx;
                            r_status <= ST_INS;
                            r_state <= S_WR;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_SRCH;
                    end
                end
                S_PURGE: begin
                    r_state <= S_PCHK;
                end
                S_PCHK: begin
                    if (r_valid[r_rd_idx] && (r_item.now - r_rd_ls) >= r_timeout) begin
                        r_valid[r_rd_idx] <= 1'b0;
                        r_removed <= r_removed + 1'b1;
                        r_stored <= r_stored - 1'b1;
                    end
                    if (r_idx == IDX_W'(TABLE_DEPTH - 1)) begin
                        r_state <= S_WR;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_PURGE;
                    end
                end
                S_WR: begin
                    if (!r_hit) begin
                        if (r_removed == '0 && r_stored == CNT_W'(TABLE_DEPTH)) begin
                            r_status <= ST_FULL;
                            r_slot <= '0;
                        end else begin
                            if (r_stored == CNT_W'(TABLE_DEPTH)) r_status <= ST_INS;
                            else if (r_removed != '0) r_status <= ST_INS_PRG;
                            else r_status <= ST_INS;
                            r_slot <= free_idx;
                            r_valid[free_idx] <= free_any;
                            r_stored <= r_stored + CNT_W'(free_any);
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_out.status <= r_status;
                    r_out.slot <= 6'(r_slot);
                    r_out.packet_count <= r_count;
                    r_out.occupancy <= 7'(r_stored);
                    r_out.purged <= 7'(r_removed);
                    r_out_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> hdl/flow_table_with_aging_core.sv
// ----------------------------------------------------------------------------
// flow_table_with_aging_core
// Flow table keyed by a symmetric IPv4 5-tuple, with idle-timeout purge.
// ----------------------------------------------------------------------------
// Channels: in_ch takes one packet header per transaction, out_ch gives one
// result per packet, cfg_ch writes the idle timeout (taken at once).
// The front builds the key and holds up to two packets in a queue; the back
// walks the entry memory one entry at a time, read then check (one read
// port). Bypassed packets skip the walk; a lookup runs to a hit or the last
// entry; a miss on a full table adds a purge walk over every entry.
// The result register holds a result until it is taken; while it is held
// the back starts no new packet, and the queue fills and drops in_ch.ready.
// Reset clears all valid bits, the occupancy and the queue at once, and
// loads the timeout with 5; no clearing pass is needed.
// ----------------------------------------------------------------------------
module flow_table_with_aging_core import ftwa_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ftwa_in_if.sink      in_ch,
    ftwa_cfg_if.sink     cfg_ch,
    ftwa_out_if.source   out_ch
);
    logic      q_valid;
    t_key_item q_data;
    logic      q_pop;

    ftwa_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_q_valid(q_valid), .o_q_data(q_data), .i_q_pop(q_pop)
    );

    ftwa_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid),
        .i_q_data(q_data), .o_q_pop(q_pop), .cfg_ch(cfg_ch), .out_ch(out_ch)
    );
endmodule

>>> hdl/ftwa_checker.sv
// ----------------------------------------------------------------------------
// ftwa_checker
// Port-level checks on the flow table.
// ----------------------------------------------------------------------------
module ftwa_checker import ftwa_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.status <= ST_BYPASS) else $error("bad status");
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.occupancy <= 7'(TABLE_DEPTH)) else $error("bad occ");
    a_full_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.status == ST_FULL || i_out_data.status == ST_BYPASS)
        |-> i_out_data.slot == '0 && i_out_data.packet_count == '0) else $error("bad fields");
    a_purge_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.purged != '0 |-> i_out_data.status == ST_INS_PRG)
        else $error("bad purge");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("output not held");
endmodule

bind flow_table_with_aging_core ftwa_checker u_ftwa_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_out_valid(out_ch.valid),
    .i_out_ready(out_ch.ready), .i_out_data(out_ch.data)
);

>>> tb/flow_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_table_checker
// Watches the packet, result and timeout channels of the flow table, keeps
// its own copy of the table and the timeout, and compares every result
// transaction field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module flow_table_checker import ftwa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    ftwa_in_if   in_mon,
    ftwa_cfg_if  cfg_mon,
    ftwa_out_if  out_mon,
    output int   o_fail_count,
    output int   o_pending
);
    logic [31:0] timeout_mirror;
    logic        flow_valid [TABLE_DEPTH];
    logic [63:0] flow_addrs [TABLE_DEPTH];
    logic [39:0] flow_ports [TABLE_DEPTH];
    logic [31:0] flow_count [TABLE_DEPTH];
    logic [31:0] flow_seen  [TABLE_DEPTH];
    int          flows_held;
    t_out_item   results_due[$];

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, field, got, want);
        o_fail_count++;
    endtask

    function automatic t_out_item track_packet(t_in_item pkt);
        t_out_item   res;
        logic [31:0] ahi, alo;
        logic [15:0] phi, plo;
        logic [63:0] kaddr;
        logic [39:0] kpp;
        int          hit_idx, free_idx, removed;
        res = '0;
        res.status = ST_BYPASS;
        removed = 0;
        if (pkt.is_ipv4) begin
            ahi = (pkt.src_addr > pkt.dst_addr) ? pkt.src_addr : pkt.dst_addr;
            alo = (pkt.src_addr > pkt.dst_addr) ? pkt.dst_addr : pkt.src_addr;
            phi = (pkt.src_port > pkt.dst_port) ? pkt.src_port : pkt.dst_port;
            plo = (pkt.src_port > pkt.dst_port) ? pkt.dst_port : pkt.src_port;
            kaddr = {ahi, alo};
            kpp = {phi, plo, pkt.protocol};
            hit_idx = -1;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (hit_idx < 0 && flow_valid[i] && flow_addrs[i] == kaddr
                        && flow_ports[i] == kpp)
                    hit_idx = i;
            end
            if (hit_idx >= 0) begin
                if (flow_count[hit_idx] != 32'hFFFF_FFFF)
                    flow_count[hit_idx]++;
                flow_seen[hit_idx] = pkt.now;
                res.status = ST_HIT;
                res.slot = hit_idx[5:0];
                res.packet_count = flow_count[hit_idx];
            end else begin
                res.status = ST_INS;
                if (flows_held >= TABLE_DEPTH) begin
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (flow_valid[i] && (pkt.now - flow_seen[i]) >= timeout_mirror) begin
                            flow_valid[i] = 1'b0;
                            removed++;
                        end
                    end
                    flows_held -= removed;
                    res.status = ST_INS_PRG;
                end
                if (flows_held >= TABLE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    free_idx = -1;
                    for (int i = 0; i < TABLE_DEPTH; i++)
                        if (free_idx < 0 && !flow_valid[i])
                            free_idx = i;
                    flow_valid[free_idx] = 1'b1;
                    flow_addrs[free_idx] = kaddr;
                    flow_ports[free_idx] = kpp;
                    flow_count[free_idx] = '0;
                    flow_seen[free_idx] = pkt.now;
                    flows_held++;
                    res.slot = free_idx[5:0];
                end
            end
        end
        res.occupancy = flows_held[6:0];
        res.purged = removed[6:0];
        return res;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            timeout_mirror = RESET_IDLE_TIMEOUT;
            flows_held = 0;
            for (int i = 0; i < TABLE_DEPTH; i++)
                flow_valid[i] = 1'b0;
        end else begin
            if (cfg_mon.valid && cfg_mon.ready)
                timeout_mirror = cfg_mon.data;
            if (in_mon.valid && in_mon.ready)
                results_due.push_back(track_packet(in_mon.data));
            if (out_mon.valid && out_mon.ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result transaction with none expected", $realtime);
                    o_fail_count++;
                end else begin
                    want = results_due.pop_front();
                    if (out_mon.data.status != want.status)
                        report_mismatch("status", out_mon.data.status, want.status);
                    if (out_mon.data.slot != want.slot)
                        report_mismatch("slot", out_mon.data.slot, want.slot);
                    if (out_mon.data.packet_count != want.packet_count)
                        report_mismatch("packet_count", out_mon.data.packet_count,
                                        want.packet_count);
                    if (out_mon.data.occupancy != want.occupancy)
                        report_mismatch("occupancy", out_mon.data.occupancy, want.occupancy);
                    if (out_mon.data.purged != want.purged)
                        report_mismatch("purged", out_mon.data.purged, want.purged);
                end
            end
        end
        o_pending = results_due.size();
    end
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the flow table: directed packets first, then phases of random
// traffic drawn mostly from a pool of flows larger than the table, under
// several idle timeouts and idling patterns, with one long result hold-off.
// ----------------------------------------------------------------------------
module tb_top import ftwa_pkg::*; ();
    localparam int PHASE_ITEMS = 330;
    localparam int POOL_SIZE   = 96;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT  = 4 * TABLE_DEPTH + 50;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count, pending, cycles;
    int   send_idle_pct, recv_stall_pct;
    logic hold_results = 1'b0;
    logic [31:0] clock_ticks;
    t_in_item    flow_pool [POOL_SIZE];

    ftwa_in_if  in_ch ();
    ftwa_out_if out_ch ();
    ftwa_cfg_if cfg_ch ();

    flow_table_with_aging_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch),
        .cfg_ch (cfg_ch),
        .out_ch (out_ch)
    );

    flow_table_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_mon      (in_ch),
        .cfg_mon     (cfg_ch),
        .out_mon     (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge i_clk)
        out_ch.ready = !hold_results && ($urandom_range(0, 99) >= recv_stall_pct);

    task automatic send_packet(t_in_item pkt);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data = pkt;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_timeout(logic [31:0] value);
        cfg_ch.valid = 1'b1;
        cfg_ch.data = value;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic wait_idle();
        in_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    function automatic t_in_item make_v4(logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
                                         logic [15:0] dp, logic [7:0] pr, logic [31:0] ts);
        t_in_item pkt;
        pkt = '{1'b1, sa, da, sp, dp, pr, ts};
        return pkt;
    endfunction

    function automatic t_in_item random_packet();
        t_in_item pkt;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            clock_ticks = $urandom;
        else
            clock_ticks = clock_ticks + $urandom_range(0, 3);
        if (pick < 8) begin
            pkt = make_v4($urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom),
                          clock_ticks);
            pkt.is_ipv4 = 1'b0;
        end else if (pick < 15) begin
            pkt = make_v4($urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom),
                          clock_ticks);
        end else begin
            pkt = flow_pool[$urandom_range(0, POOL_SIZE - 1)];
            if ($urandom_range(0, 1))
                pkt = make_v4(pkt.dst_addr, pkt.src_addr, pkt.dst_port, pkt.src_port,
                              pkt.protocol, 32'd0);
        end
        pkt.now = clock_ticks;
        return pkt;
    endfunction

    initial begin
        logic [31:0] phase_timeout [6];
        int          phase_send [6];
        int          phase_recv [6];
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        clock_ticks = 32'hFFFF_FFF0;
        phase_timeout = '{RESET_IDLE_TIMEOUT, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd3, 32'd0};
        phase_timeout[5] = $urandom_range(2, 40);
        phase_send = '{0, 50, 0, 20, 0, 50};
        phase_recv = '{0, 0, 50, 20, 0, 50};
        for (int i = 0; i < POOL_SIZE; i++)
            flow_pool[i] = make_v4($urandom, $urandom, 16'($urandom), 16'($urandom),
                                   8'($urandom), 32'd0);
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: bypass, extremes, symmetry, wrap of the timestamp
        send_packet('{1'b0, '1, '1, '1, '1, '1, '1});
        send_packet(make_v4('0, '0, '0, '0, '0, 32'hFFFF_FFFE));
        send_packet(make_v4('0, '0, '0, '0, '0, 32'hFFFF_FFFF));
        send_packet(make_v4('1, '1, '1, '1, '1, 32'd0));
        send_packet(make_v4('1, '1, '1, '1, '1, 32'd1));
        send_packet(make_v4(32'h0A00_0001, 32'hC0A8_0102, 16'd80, 16'd5555, 8'd6, 32'd2));
        send_packet(make_v4(32'hC0A8_0102, 32'h0A00_0001, 16'd5555, 16'd80, 8'd6, 32'd3));
        send_packet(make_v4(32'hC0A8_0102, 32'h0A00_0001, 16'd5555, 16'd80, 8'd17, 32'd3));
        send_packet(make_v4(32'hC0A8_0102, 32'h0A00_0001, 16'd80, 16'd5555, 8'd6, 32'd4));
        send_packet('{1'b0, '0, '0, '0, '0, '0, '0});
        send_packet(make_v4(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF, 8'h80, 32'd4));
        send_packet(make_v4(32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 16'h8000, 8'h80, 32'd4));
        clock_ticks = 32'd4;

        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            write_timeout(phase_timeout[ph]);
            send_idle_pct = phase_send[ph];
            recv_stall_pct = phase_recv[ph];
            if (ph == 4)
                fork
                    begin
                        hold_results = 1'b1;
                        repeat (2000) @(negedge i_clk);
                        hold_results = 1'b0;
                    end
                join_none
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_packet(random_packet());
        end

        wait_idle();
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
